### rtl/core/stad_pkg.sv
// ============================================================================
// stad_pkg
// Shared types, codes and constants of the table-driven stepper driver.
// ============================================================================
package stad_pkg;

    localparam int POS_W    = 12;
    localparam int VEL_W    = 16;
    localparam int TICK_W   = 16;
    localparam int PHASE_W  = 3;
    localparam int COIL_W   = 4;
    localparam int ROWS     = 5;
    localparam int ROW_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Item operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_GOTO = 2'd1;
    localparam logic [1:0] OP_ZERO = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STEPS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ROW0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ROW1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ROW2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ROW3  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ROW4  = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [POS_W-1:0]  TOTAL_STEPS_RST = 12'd945;
    localparam logic [TICK_W-1:0] ZERO_PERIOD_RST = 16'd950;
    localparam logic [ROWS-1:0][ROW_W-1:0] ACCEL_ROWS_RST = {
        32'd19661400, 32'd9831200, 32'd6554600, 32'd3278300, 32'd1313720
    };

    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;
    localparam logic [TICK_W-1:0]  TICK_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [POS_W-1:0]   total_steps;
        logic [TICK_W-1:0]  zero_period;
        logic [ROWS-1:0][ROW_W-1:0] rows;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   cur_pos;
        logic [POS_W-1:0]   target;
        logic [PHASE_W-1:0] phase;
        logic [VEL_W-1:0]   velocity;
        logic               direction_up;
        logic               halted;
        logic [TICK_W-1:0]  elapsed;
        logic [TICK_W-1:0]  step_delay;
        logic [COIL_W-1:0]  coil;
        logic               zeroing;
        logic [POS_W-1:0]   zero_left;
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [PHASE_W-1:0] phase;
        logic [COIL_W-1:0]  coil;
    } motion_t;

    localparam state_t STATE_RST = '{
        cur_pos: '0, target: '0, phase: '0, velocity: '0, direction_up: 1'b0,
        halted: 1'b1, elapsed: '0, step_delay: '0, coil: '0, zeroing: 1'b0,
        zero_left: '0
    };

    // Six-phase coil drive pattern, pin 1 in bit 3.
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            3'd0:    c = 4'h9;
            3'd1:    c = 4'h1;
            3'd2:    c = 4'h7;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'hE;
            3'd5:    c = 4'h8;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/stad_step.sv
// ============================================================================
// stad_step
// Next-state logic for one item: ticks, goto commands and the zeroing sweep.
// ============================================================================
module stad_step (
    input  stad_pkg::state_t    cur,
    input  stad_pkg::cfg_t      cfg,
    input  logic [1:0]          op,
    input  logic [stad_pkg::POS_W-1:0] target_pos,
    output stad_pkg::state_t    nxt
);

    function automatic stad_pkg::motion_t go_up(
        input logic [stad_pkg::POS_W-1:0]   pos,
        input logic [stad_pkg::PHASE_W-1:0] ph,
        input logic [stad_pkg::COIL_W-1:0]  coil,
        input logic [stad_pkg::POS_W-1:0]   lim
    );
        stad_pkg::motion_t m;
        m.pos   = pos;
        m.phase = ph;
        m.coil  = coil;
        if (pos < lim)
        begin
            m.pos   = pos + 1'b1;
            m.phase = (ph >= stad_pkg::PHASE_LAST) ? '0 : ph + 1'b1;
            m.coil  = stad_pkg::coil_pattern(m.phase);
        end
        return m;
    endfunction

    function automatic stad_pkg::motion_t go_down(
        input logic [stad_pkg::POS_W-1:0]   pos,
        input logic [stad_pkg::PHASE_W-1:0] ph,
        input logic [stad_pkg::COIL_W-1:0]  coil
    );
        stad_pkg::motion_t m;
        m.pos   = pos;
        m.phase = ph;
        m.coil  = coil;
        if (pos != '0)
        begin
            m.pos   = pos - 1'b1;
            m.phase = (ph == '0 || ph > stad_pkg::PHASE_LAST) ? stad_pkg::PHASE_LAST
                                                             : ph - 1'b1;
            m.coil  = stad_pkg::coil_pattern(m.phase);
        end
        return m;
    endfunction

    logic [stad_pkg::POS_W-1:0]  eff_steps;
    logic [stad_pkg::POS_W-1:0]  lim;
    logic [stad_pkg::TICK_W-1:0] el_inc;
    logic [stad_pkg::VEL_W-1:0]  max_vel;

    // Step-taking path, worked out for every item and used on a due tick.
    logic                        ts_stop;
    logic                        ts_dir;
    logic [stad_pkg::VEL_W-1:0]  ts_vel0;
    stad_pkg::motion_t           ts_move;
    logic                        ts_ahead;
    logic [stad_pkg::POS_W-1:0]  ts_dist;
    logic [stad_pkg::VEL_W-1:0]  ts_vel;
    logic [stad_pkg::TICK_W-1:0] ts_delay;

    stad_pkg::motion_t           zr_move;
    stad_pkg::motion_t           zs_move;
    logic [stad_pkg::POS_W-1:0]  zl_dec;

    always_comb
    begin
        eff_steps = (cfg.total_steps == '0) ? {{(stad_pkg::POS_W-1){1'b0}}, 1'b1}
                                            : cfg.total_steps;
        lim       = eff_steps - 1'b1;
        el_inc    = (cur.elapsed == stad_pkg::TICK_MAX) ? cur.elapsed : cur.elapsed + 1'b1;
        max_vel   = cfg.rows[stad_pkg::ROWS-1][31:16];

        ts_stop = (cur.cur_pos == cur.target) && (cur.velocity == '0);
        ts_dir  = (cur.velocity == '0) ? (cur.cur_pos < cur.target) : cur.direction_up;
        ts_vel0 = (cur.velocity == '0) ? {{(stad_pkg::VEL_W-1){1'b0}}, 1'b1} : cur.velocity;
        ts_move = ts_dir ? go_up(cur.cur_pos, cur.phase, cur.coil, lim)
                         : go_down(cur.cur_pos, cur.phase, cur.coil);
        ts_ahead = ts_dir ? (cur.target > ts_move.pos) : (ts_move.pos > cur.target);
        ts_dist  = ts_dir ? (cur.target - ts_move.pos) : (ts_move.pos - cur.target);
        if (!ts_ahead)
            ts_vel = ts_vel0 - 1'b1;
        else if ({{(stad_pkg::VEL_W-stad_pkg::POS_W){1'b0}}, ts_dist} < ts_vel0)
            ts_vel = ts_vel0 - 1'b1;
        else if (ts_vel0 < max_vel)
            ts_vel = ts_vel0 + 1'b1;
        else
            ts_vel = ts_vel0;

        // First row whose threshold covers the velocity; the last row otherwise.
        ts_delay = cfg.rows[stad_pkg::ROWS-1][15:0];
        for (int i = stad_pkg::ROWS - 1; i >= 0; i--)
        begin
            if (cfg.rows[i][31:16] >= ts_vel)
                ts_delay = cfg.rows[i][15:0];
        end

        zr_move = go_down(lim, cur.phase, cur.coil);
        zs_move = go_down(cur.cur_pos, cur.phase, cur.coil);
        zl_dec  = cur.zero_left - 1'b1;

        nxt = cur;
        case (op)
            stad_pkg::OP_TICK:
            begin
                if (cur.zeroing)
                begin
                    if (el_inc >= cfg.zero_period)
                    begin
                        nxt.elapsed   = '0;
                        nxt.zero_left = zl_dec;
                        if (zl_dec == '0)
                        begin
                            nxt.zeroing      = 1'b0;
                            nxt.cur_pos      = '0;
                            nxt.target       = '0;
                            nxt.velocity     = '0;
                            nxt.direction_up = 1'b0;
                            nxt.halted       = 1'b1;
                            nxt.coil         = '0;
                        end
                        else
                        begin
                            nxt.cur_pos = zs_move.pos;
                            nxt.phase   = zs_move.phase;
                            nxt.coil    = zs_move.coil;
                        end
                    end
                    else
                    begin
                        nxt.elapsed = el_inc;
                    end
                end
                else if (!cur.halted)
                begin
                    if (el_inc >= cur.step_delay)
                    begin
                        nxt.elapsed = '0;
                        if (ts_stop)
                        begin
                            nxt.halted       = 1'b1;
                            nxt.direction_up = 1'b0;
                            nxt.coil         = '0;
                        end
                        else
                        begin
                            nxt.direction_up = ts_dir;
                            nxt.cur_pos      = ts_move.pos;
                            nxt.phase        = ts_move.phase;
                            nxt.coil         = ts_move.coil;
                            nxt.velocity     = ts_vel;
                            nxt.step_delay   = ts_delay;
                        end
                    end
                    else
                    begin
                        nxt.elapsed = el_inc;
                    end
                end
            end
            stad_pkg::OP_GOTO:
            begin
                if (!cur.zeroing)
                begin
                    nxt.target = (target_pos > lim) ? lim : target_pos;
                    if (cur.halted)
                    begin
                        nxt.halted     = 1'b0;
                        nxt.elapsed    = '0;
                        nxt.step_delay = '0;
                    end
                end
            end
            stad_pkg::OP_ZERO:
            begin
                nxt.zeroing   = 1'b1;
                nxt.zero_left = eff_steps;
                nxt.elapsed   = '0;
                nxt.cur_pos   = zr_move.pos;
                nxt.phase     = zr_move.phase;
                nxt.coil      = zr_move.coil;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/core/stepper_accel_table_driver_core.sv
// ============================================================================
// stepper_accel_table_driver_core
// Six-phase stepper driver with table-driven acceleration and a zeroing sweep.
// ============================================================================
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ---------------------------------
//   input     in_valid / in_stall     op, target_pos
//   result    out_valid / out_stall   coils, position, busy_res
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every accepted item gives exactly one result item, via the input register
// and then the result register. One item is taken in every cycle while the
// result side does not stall: the input register feeds the next-state logic,
// whose outputs update the motor state and the result register at the same
// edge. A stall on the result side holds the result register and, through
// it, the input register; in_stall then rises in the same cycle. Reset
// clears the motor state to halted at position 0 and loads the default
// configuration. Configuration writes are always taken (cfg_ready is held
// high); an index beyond the register list is ignored.
//
module stepper_accel_table_driver_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [stad_pkg::POS_W-1:0] target_pos,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [stad_pkg::COIL_W-1:0] coils,
    output logic [stad_pkg::POS_W-1:0]  position,
    output logic        busy_res,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [stad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stad_pkg::ROW_W-1:0]     cfg_data
);

    stad_pkg::cfg_t   cfg_reg;
    stad_pkg::state_t state_reg;
    stad_pkg::state_t state_next;

    logic                        in_vld_reg;
    logic [1:0]                  op_reg;
    logic [stad_pkg::POS_W-1:0]  tpos_reg;

    logic                        out_vld_reg;
    logic [stad_pkg::COIL_W-1:0] coils_reg;
    logic [stad_pkg::POS_W-1:0]  position_reg;
    logic                        busy_reg;

    logic advance;
    logic in_take;

    // The working stage moves on whenever the result register is free or
    // its item is being taken.
    assign advance   = !out_vld_reg || !out_stall;
    assign in_stall  = in_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    stad_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .op         (op_reg),
        .target_pos (tpos_reg),
        .nxt        (state_next)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_steps <= stad_pkg::TOTAL_STEPS_RST;
            cfg_reg.zero_period <= stad_pkg::ZERO_PERIOD_RST;
            cfg_reg.rows        <= stad_pkg::ACCEL_ROWS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                stad_pkg::CFG_TOTAL_STEPS: cfg_reg.total_steps <= cfg_data[stad_pkg::POS_W-1:0];
                stad_pkg::CFG_ZERO_PERIOD: cfg_reg.zero_period <= cfg_data[stad_pkg::TICK_W-1:0];
                stad_pkg::CFG_ACCEL_ROW0:  cfg_reg.rows[0] <= cfg_data;
                stad_pkg::CFG_ACCEL_ROW1:  cfg_reg.rows[1] <= cfg_data;
                stad_pkg::CFG_ACCEL_ROW2:  cfg_reg.rows[2] <= cfg_data;
                stad_pkg::CFG_ACCEL_ROW3:  cfg_reg.rows[3] <= cfg_data;
                stad_pkg::CFG_ACCEL_ROW4:  cfg_reg.rows[4] <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Control state: valid flags and the motor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= stad_pkg::STATE_RST;
        end
        else
        begin
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
                if (in_vld_reg)
                    state_reg <= state_next;
            end
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= op;
            tpos_reg <= target_pos;
        end
        if (advance && in_vld_reg)
        begin
            coils_reg    <= state_next.coil;
            position_reg <= state_next.cur_pos;
            busy_reg     <= state_next.zeroing || !state_next.halted;
        end
    end

    assign out_valid = out_vld_reg;
    assign coils     = coils_reg;
    assign position  = position_reg;
    assign busy_res  = busy_reg;

endmodule

### sim/stepper_accel_table_driver_core_checker.sv
// ----------------------------------------------------------------------------
// Stepper driver checker
// Watches the item, result and register channels of the stepper driver core,
// keeps its own copy of the motor state, predicts one reading per item and
// compares every returned reading field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stepper_accel_table_driver_core_checker
    import stad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [POS_W-1:0]     target_pos,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [COIL_W-1:0]    coils,
    input  logic [POS_W-1:0]     position,
    input  logic                 busy_res,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   readings_due,
    output int                   readings_seen,
    output int                   steps_taken,
    output int                   sweeps_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic [POS_W-1:0]  position;
        logic              busy;
    } drive_reading_t;

    // Coil drive for phases 0 to 5, phase 0 in the lowest nibble.
    localparam logic [5:0][COIL_W-1:0] PHASE_COILS = {4'h8, 4'hE, 4'h6, 4'h7, 4'h1, 4'h9};

    drive_reading_t expected_readings[$];

    logic [POS_W-1:0]   cfg_travel;
    logic [TICK_W-1:0]  cfg_zero_period;
    logic [ROW_W-1:0]   cfg_rows [ROWS];

    logic [POS_W-1:0]   m_pos;
    logic [POS_W-1:0]   m_target;
    logic [PHASE_W-1:0] m_phase;
    logic [VEL_W-1:0]   m_vel;
    logic               m_up;
    logic               m_halted;
    logic [TICK_W-1:0]  m_elapsed;
    logic [TICK_W-1:0]  m_delay;
    logic [COIL_W-1:0]  m_coil;
    logic               m_zeroing;
    logic [POS_W-1:0]   m_zero_left;

    // A travel of zero steps behaves as a travel of one.
    function automatic logic [POS_W-1:0] usable_travel();
        return (cfg_travel == '0) ? POS_W'(1) : cfg_travel;
    endfunction

    task automatic reset_motor();
        cfg_travel      = TOTAL_STEPS_RST;
        cfg_zero_period = ZERO_PERIOD_RST;
        for (int i = 0; i < ROWS; i++)
            cfg_rows[i] = ACCEL_ROWS_RST[i];
        m_pos       = '0;
        m_target    = '0;
        m_phase     = '0;
        m_vel       = '0;
        m_up        = 1'b0;
        m_halted    = 1'b1;
        m_elapsed   = '0;
        m_delay     = '0;
        m_coil      = '0;
        m_zeroing   = 1'b0;
        m_zero_left = '0;
    endtask

    task automatic step_up();
        if (m_pos < usable_travel() - POS_W'(1)) begin
            m_pos   = m_pos + 1'b1;
            m_phase = (m_phase >= 3'd5) ? 3'd0 : m_phase + 1'b1;
            m_coil  = PHASE_COILS[m_phase];
            steps_taken++;
        end
    endtask

    task automatic step_down();
        if (m_pos != '0) begin
            m_pos   = m_pos - 1'b1;
            m_phase = (m_phase == 3'd0 || m_phase > 3'd5) ? 3'd5 : m_phase - 1'b1;
            m_coil  = PHASE_COILS[m_phase];
            steps_taken++;
        end
    endtask

    // One step of a move, with the velocity update and the next delay.
    task automatic move_one_step();
        int pos_now;
        int tgt_now;
        int remaining;
        int vel_now;
        int top_vel;
        int row_hit;
        top_vel = cfg_rows[ROWS-1][ROW_W-1:16];
        if (m_pos == m_target && m_vel == '0) begin
            m_halted = 1'b1;
            m_up     = 1'b0;
            m_coil   = '0;
        end else begin
            if (m_vel == '0) begin
                m_up  = (m_pos < m_target);
                m_vel = VEL_W'(1);
            end
            if (m_up)
                step_up();
            else
                step_down();
            pos_now = m_pos;
            tgt_now = m_target;
            vel_now = m_vel;
            remaining = m_up ? tgt_now - pos_now : pos_now - tgt_now;
            if (remaining > 0) begin
                if (remaining < vel_now)
                    m_vel = m_vel - 1'b1;
                else if (vel_now < top_vel)
                    m_vel = m_vel + 1'b1;
            end else begin
                m_vel = m_vel - 1'b1;
            end
            // First row whose threshold covers the velocity, else the last row.
            row_hit = ROWS - 1;
            for (int i = ROWS - 1; i >= 0; i--)
                if (cfg_rows[i][ROW_W-1:16] >= m_vel)
                    row_hit = i;
            m_delay = cfg_rows[row_hit][15:0];
        end
    endtask

    task automatic predict_reading(input logic [1:0] code, input logic [POS_W-1:0] tgt);
        logic [POS_W-1:0] limit;
        drive_reading_t   reading;
        case (code)
            OP_TICK: begin
                if (m_zeroing) begin
                    if (m_elapsed != TICK_MAX)
                        m_elapsed = m_elapsed + 1'b1;
                    if (m_elapsed >= cfg_zero_period) begin
                        m_elapsed   = '0;
                        m_zero_left = m_zero_left - 1'b1;
                        if (m_zero_left == '0) begin
                            m_zeroing = 1'b0;
                            m_pos     = '0;
                            m_target  = '0;
                            m_vel     = '0;
                            m_up      = 1'b0;
                            m_halted  = 1'b1;
                            m_coil    = '0;
                            sweeps_done++;
                        end else begin
                            step_down();
                        end
                    end
                end else if (!m_halted) begin
                    if (m_elapsed != TICK_MAX)
                        m_elapsed = m_elapsed + 1'b1;
                    if (m_elapsed >= m_delay) begin
                        move_one_step();
                        m_elapsed = '0;
                    end
                end
            end
            OP_GOTO: begin
                if (!m_zeroing) begin
                    limit    = usable_travel() - POS_W'(1);
                    m_target = (tgt > limit) ? limit : tgt;
                    if (m_halted) begin
                        m_halted  = 1'b0;
                        m_elapsed = '0;
                        m_delay   = '0;
                    end
                end
            end
            OP_ZERO: begin
                m_zeroing   = 1'b1;
                m_pos       = usable_travel() - POS_W'(1);
                m_zero_left = usable_travel();
                m_elapsed   = '0;
                step_down();
            end
            default: ;
        endcase
        reading.coils    = m_coil;
        reading.position = m_pos;
        reading.busy     = m_zeroing || !m_halted;
        expected_readings.push_back(reading);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_reading();
        drive_reading_t want;
        if (expected_readings.size() == 0) begin
            report_mismatch("reading with nothing expected, position", position, -1);
        end else begin
            want = expected_readings.pop_front();
            if (coils !== want.coils)
                report_mismatch("coils", coils, want.coils);
            if (position !== want.position)
                report_mismatch("position", position, want.position);
            if (busy_res !== want.busy)
                report_mismatch("busy_res", busy_res, want.busy);
        end
        readings_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reset_motor();
            expected_readings.delete();
            readings_due = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TOTAL_STEPS: cfg_travel = cfg_data[POS_W-1:0];
                    CFG_ZERO_PERIOD: cfg_zero_period = cfg_data[TICK_W-1:0];
                    CFG_ACCEL_ROW0, CFG_ACCEL_ROW1, CFG_ACCEL_ROW2,
                    CFG_ACCEL_ROW3, CFG_ACCEL_ROW4:
                        cfg_rows[cfg_index - CFG_ACCEL_ROW0] = cfg_data;
                    default: ;
                endcase
            end
            // A reading leaving now belongs to an item taken at an earlier edge.
            if (out_valid && !out_stall)
                check_reading();
            if (in_valid && !in_stall)
                predict_reading(op, target_pos);
            readings_due = expected_readings.size();
        end
    end

endmodule

### sim/stepper_accel_table_driver_core_tb.sv
// ----------------------------------------------------------------------------
// Stepper driver core regression
// Drives ticks, goto and zeroing items into the stepper driver core under a
// range of register settings, with random idling on both channels, while a
// separate checker predicts and compares every reading.
// ----------------------------------------------------------------------------
module stepper_accel_table_driver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stad_pkg::*;

    // The opcode that the block leaves unused; it must change nothing.
    localparam logic [1:0] OP_SPARE = 2'd3;
    // A register index past the end of the list; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    // The watchdog stops the run when the cycle count reaches this.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 115;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           op = OP_TICK;
    logic [POS_W-1:0]     target_pos = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COIL_W-1:0]    coils;
    logic [POS_W-1:0]     position;
    logic                 busy_res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TOTAL_STEPS;
    logic [ROW_W-1:0]     cfg_data = '0;

    int mismatches;
    int readings_due;
    int readings_seen;
    int steps_taken;
    int sweeps_done;

    int items_sent = 0;
    int settings_loaded = 0;
    int cycle_count = 0;
    // Travel in force, as the block sees it, for choosing sensible targets.
    int travel_now = 945;
    // Idling: zero means none, otherwise one chance in this many, per item for
    // input gaps and per cycle for result stalls, of starting an idle burst.
    int gap_rate = 0;
    int stall_rate = 0;
    int stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    stepper_accel_table_driver_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .target_pos (target_pos),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coils      (coils),
        .position   (position),
        .busy_res   (busy_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    stepper_accel_table_driver_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .target_pos    (target_pos),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coils         (coils),
        .position      (position),
        .busy_res      (busy_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .readings_due  (readings_due),
        .readings_seen (readings_seen),
        .steps_taken   (steps_taken),
        .sweeps_done   (sweeps_done)
    );

    // The result side holds off in random bursts. It changes only at the
    // falling edge, so the block sees a steady stall at every rising edge.
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
            if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1)
                stall_left = $urandom_range(1, 9);
        end
    end

    // Watchdog: a hung handshake or a reading that never comes ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d readings outstanding.",
                     cycle_count, readings_due);
            $display("stepper_accel_table_driver_core regression: fail");
            $finish;
        end
    end

    function automatic logic [ROW_W-1:0] make_row(input logic [15:0] thresh,
                                                  input logic [15:0] delay);
        return {thresh, delay};
    endfunction

    // Every task below starts and ends at a falling edge. Valid is raised with
    // the payload, held until the block takes the item at a rising edge with
    // no stall, then dropped at the next falling edge. A following item raises
    // it again in the same step, so back-to-back items see a steady valid.
    task automatic send_item(input logic [1:0] code, input logic [POS_W-1:0] tgt);
        if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1)
            repeat ($urandom_range(1, 9)) @(negedge clk);
        op         = code;
        target_pos = tgt;
        in_valid   = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_item(OP_TICK, POS_W'($urandom_range(0, 4095)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every predicted reading has come back, then a few cycles
    // more to cover the two-stage pipeline, so that the block is idle.
    task automatic settle();
        while (readings_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_setting(input logic [POS_W-1:0] travel, input logic [TICK_W-1:0] period,
                                input logic [ROW_W-1:0] row0, input logic [ROW_W-1:0] row1,
                                input logic [ROW_W-1:0] row2, input logic [ROW_W-1:0] row3,
                                input logic [ROW_W-1:0] row4);
        write_reg(CFG_TOTAL_STEPS, ROW_W'(travel));
        write_reg(CFG_ZERO_PERIOD, ROW_W'(period));
        write_reg(CFG_ACCEL_ROW0, row0);
        write_reg(CFG_ACCEL_ROW1, row1);
        write_reg(CFG_ACCEL_ROW2, row2);
        write_reg(CFG_ACCEL_ROW3, row3);
        write_reg(CFG_ACCEL_ROW4, row4);
        travel_now = (travel == '0) ? 1 : int'(travel);
        settings_loaded++;
    endtask

    // Random settings keep the delays and, bar full travel, the travel short so
    // that moves finish, reverse and decelerate often, and sweeps can run to the
    // end. Thresholds rise from row to row; repeated thresholds are allowed.
    task automatic load_random_setting(input bit full_travel);
        logic [POS_W-1:0]  travel;
        logic [15:0]       thresh;
        logic [ROW_W-1:0]  rows [ROWS];
        case ($urandom_range(0, 5))
            0:       travel = POS_W'($urandom_range(0, 1));
            1:       travel = POS_W'($urandom_range(25, 200));
            default: travel = POS_W'($urandom_range(2, 24));
        endcase
        if (full_travel)
            travel = POS_W'(4095);
        thresh = 16'($urandom_range(0, 2));
        for (int i = 0; i < ROWS; i++) begin
            rows[i] = make_row(thresh, 16'($urandom_range(0, 5)));
            thresh  = thresh + 16'($urandom_range(0, 3));
        end
        load_setting(travel, TICK_W'($urandom_range(0, 3)),
                     rows[0], rows[1], rows[2], rows[3], rows[4]);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNMAPPED, $urandom);
    endtask

    // Mostly ticks, so that moves and sweeps make progress, with gotos to
    // targets inside the travel, some targets beyond it, occasional sweeps
    // and the odd unused opcode. Now and then the sender holds back until
    // every reading is home before carrying on.
    task automatic run_random_items(input int count, input int zero_weight);
        int roll;
        logic [POS_W-1:0] tgt;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                tgt = POS_W'($urandom_range(0, 4095));
            else
                tgt = POS_W'($urandom_range(0, travel_now - 1));
            if (roll < 14)
                send_item(OP_GOTO, tgt);
            else if (roll < 14 + zero_weight)
                send_item(OP_ZERO, tgt);
            else if (roll < 18 + zero_weight)
                send_item(OP_SPARE, tgt);
            else
                send_item(OP_TICK, tgt);
            if ($urandom_range(0, 199) == 0)
                settle();
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        gap_rate   = 4;
        stall_rate = 4;

        // Reset settings: the unused opcode, then a goto from rest, which
        // steps on the very next tick; the long default delays stop it there.
        send_item(OP_SPARE, POS_W'(4095));
        send_item(OP_GOTO, POS_W'(3));
        send_ticks(2);

        // Full travel with fast rows and a zero sweep period, which behaves
        // as a period of one. A target past the end is clamped, a target
        // change mid-move makes the motor decelerate and reverse, a goto
        // during a sweep is ignored and a second sweep restarts it.
        settle();
        load_setting(POS_W'(4095), TICK_W'(0), make_row(1, 0), make_row(2, 0),
                     make_row(3, 1), make_row(5, 1), make_row(8, 2));
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        send_item(OP_GOTO, POS_W'(4095));
        send_ticks(3);
        send_item(OP_GOTO, POS_W'(0));
        send_ticks(4);
        send_item(OP_ZERO, POS_W'(0));
        send_item(OP_GOTO, POS_W'(100));
        send_ticks(2);
        send_item(OP_ZERO, POS_W'(4095));

        // Zero travel acts as one step of travel. No threshold covers any
        // velocity, so the last row's delay applies.
        settle();
        load_setting(POS_W'(0), TICK_W'(1), '0, '0, '0, '0, make_row(0, 2));
        send_item(OP_GOTO, POS_W'(4095));
        send_ticks(1);
        send_item(OP_ZERO, POS_W'(0));
        send_ticks(2);
        send_item(OP_GOTO, POS_W'(0));
        send_ticks(1);

        // Top thresholds everywhere with a longer delay and sweep period.
        // After its one step the motor waits out the whole delay before it
        // sees that it has arrived and halts. Idling is off to keep it quick.
        settle();
        gap_rate   = 0;
        stall_rate = 0;
        load_setting(POS_W'(2), TICK_W'(20), make_row(16'hFFFF, 40),
                     make_row(16'hFFFF, 40), make_row(16'hFFFF, 40),
                     make_row(16'hFFFF, 40), make_row(16'hFFFF, 40));
        send_item(OP_GOTO, POS_W'(1));
        send_ticks(45);
        send_item(OP_ZERO, POS_W'(0));
        send_ticks(3);

        // Random settings and items; one phase uses the full travel. The
        // last phase runs with no idling on either side.
        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            settle();
            if (phase_no == RANDOM_PHASES - 1) begin
                gap_rate   = 0;
                stall_rate = 0;
            end else begin
                gap_rate   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                stall_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            end
            load_random_setting(phase_no == 5);
            run_random_items(ITEMS_PER_PHASE, $urandom_range(1, 5));
        end

        while (readings_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d items under %0d register settings and checked %0d readings;",
                 items_sent, settings_loaded, readings_seen);
        $display("the motor took %0d steps and %0d zeroing sweeps ran to the end.",
                 steps_taken, sweeps_done);
        if (mismatches == 0 && readings_due == 0)
            $display("stepper_accel_table_driver_core regression: pass");
        else
            $display("stepper_accel_table_driver_core regression: fail");
        $finish;
    end

endmodule

### stepper_accel_table_driver_core.f
rtl/core/stad_pkg.sv
rtl/core/stad_step.sv
rtl/core/stepper_accel_table_driver_core.sv
sim/stepper_accel_table_driver_core_checker.sv
sim/stepper_accel_table_driver_core_tb.sv
